>>> hdl/lspr_pkg.sv
// ----------------------------------------------------------------------------
// Layer II sample requantizer package
// Shared constants, class table and lane request type for the requantizer.
// ----------------------------------------------------------------------------
package lspr_pkg;

    // Q14 fixed point for the requantized samples.
    localparam int FRAC_BITS   = 14;
    localparam int CLASS_W     = 5;
    localparam int CODE_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int NBITS_W     = 5;
    localparam int GRP_W       = 3;
    localparam int LEVEL_W     = 4;
    localparam int MULC_W      = 15;
    localparam int ADDD_W      = 14;

    // Grouped codewords are at most ten bits wide.
    localparam int WORD_W      = 10;
    localparam int Q1_W        = 9;
    localparam int Q2_W        = 4;
    localparam int DIGIT_W     = 4;

    // Reciprocals are scaled by two to the power of RECIP_SHIFT.
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 17;
    localparam int RPROD_W     = WORD_W + RECIP_W;

    // Output queue.
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [GRP_W-1:0]   grp;
        logic [NBITS_W-1:0] nbits;
        logic [LEVEL_W-1:0] levels;
        logic [MULC_W-1:0]  mulc;
        logic [ADDD_W-1:0]  addd;
        logic [RECIP_W-1:0] recip1;
        logic [RECIP_W-1:0] recip2;
    } t_qclass;

    // One level code handed to a lane, with its class constants.
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [NBITS_W-1:0] nb;
        logic [MULC_W-1:0]  mulc;
        logic [ADDD_W-1:0]  addd;
    } t_lane_req;

    // Class table. recip1 is the reciprocal of the level count and recip2 of
    // its square; both are exact over the codeword range of their class.
    // Classes without a meaning get C and D of zero, so they give zero.
    function automatic t_qclass lspr_class(input logic [CLASS_W-1:0] idx);
        t_qclass q;
        begin
            q        = '0;
            q.nbits  = NBITS_W'(16);
            unique case (idx)
                5'd0: begin
                    q.grp = 3'd2; q.nbits = 5'd5; q.levels = 4'd3;
                    q.mulc = 15'h5555; q.addd = 14'h2000;
                    q.recip1 = 16'd43691; q.recip2 = 16'd14564;
                end
                5'd1: begin
                    q.grp = 3'd3; q.nbits = 5'd7; q.levels = 4'd5;
                    q.mulc = 15'h6666; q.addd = 14'h2000;
                    q.recip1 = 16'd26215; q.recip2 = 16'd5243;
                end
                5'd2: begin
                    q.nbits = 5'd3; q.mulc = 15'h4925; q.addd = 14'h1000;
                end
                5'd3: begin
                    q.grp = 3'd4; q.nbits = 5'd10; q.levels = 4'd9;
                    q.mulc = 15'h71c7; q.addd = 14'h2000;
                    q.recip1 = 16'd14564; q.recip2 = 16'd1619;
                end
                5'd4:  begin q.nbits = 5'd4;  q.mulc = 15'h4444; q.addd = 14'h0800; end
                5'd5:  begin q.nbits = 5'd5;  q.mulc = 15'h4211; q.addd = 14'h0400; end
                5'd6:  begin q.nbits = 5'd6;  q.mulc = 15'h4104; q.addd = 14'h0200; end
                5'd7:  begin q.nbits = 5'd7;  q.mulc = 15'h4081; q.addd = 14'h0100; end
                5'd8:  begin q.nbits = 5'd8;  q.mulc = 15'h4040; q.addd = 14'h0080; end
                5'd9:  begin q.nbits = 5'd9;  q.mulc = 15'h4020; q.addd = 14'h0040; end
                5'd10: begin q.nbits = 5'd10; q.mulc = 15'h4010; q.addd = 14'h0020; end
                5'd11: begin q.nbits = 5'd11; q.mulc = 15'h4008; q.addd = 14'h0010; end
                5'd12: begin q.nbits = 5'd12; q.mulc = 15'h4004; q.addd = 14'h0008; end
                5'd13: begin q.nbits = 5'd13; q.mulc = 15'h4002; q.addd = 14'h0004; end
                5'd14: begin q.nbits = 5'd14; q.mulc = 15'h4001; q.addd = 14'h0002; end
                5'd15: begin q.nbits = 5'd15; q.mulc = 15'h4001; q.addd = 14'h0001; end
                5'd16: begin q.nbits = 5'd16; q.mulc = 15'h4000; q.addd = 14'h0001; end
                default: begin
                    q.nbits = NBITS_W'(16);
                end
            endcase
            return q;
        end
    endfunction

endpackage

>>> hdl/lspr_split.sv
// ----------------------------------------------------------------------------
// Layer II sample requantizer: code split
// Splits a grouped codeword into three level digits, or passes the three
// codes through for other classes, and forms one lane request per sample.
// ----------------------------------------------------------------------------
module lspr_split import lspr_pkg::*; (
    input  logic               i_clk,
    input  logic [CLASS_W-1:0] i_class_index,
    input  logic [CODE_W-1:0]  i_code_a,
    input  logic [CODE_W-1:0]  i_code_b,
    input  logic [CODE_W-1:0]  i_code_c,
    output t_lane_req          o_req_a,
    output t_lane_req          o_req_b,
    output t_lane_req          o_req_c
);

    t_qclass             w_qin;
    t_qclass             w_qreg;
    logic [WORD_W-1:0]   n_word;
    logic [RPROD_W-1:0]  n_p1;
    logic [RPROD_W-1:0]  n_p2;

    logic [CLASS_W-1:0]  r_cls;
    logic [WORD_W-1:0]   r_word;
    logic [Q1_W-1:0]     r_q1;
    logic [Q2_W-1:0]     r_q2;
    logic [CODE_W-1:0]   r_code_a;
    logic [CODE_W-1:0]   r_code_b;
    logic [CODE_W-1:0]   r_code_c;

    logic [LEVEL_W-1:0]  w_lv;
    logic [DIGIT_W-1:0]  w_d0;
    logic [DIGIT_W-1:0]  w_d1;
    logic [DIGIT_W-1:0]  w_d2;
    logic                w_grouped;
    logic [NBITS_W-1:0]  w_nb;

    // Quotients by the level count and its square through reciprocals.
    always_comb begin
        w_qin  = lspr_class(i_class_index);
        n_word = i_code_a[WORD_W-1:0] & ~({WORD_W{1'b1}} << w_qin.nbits);
        n_p1   = RPROD_W'(n_word) * RPROD_W'(w_qin.recip1);
        n_p2   = RPROD_W'(n_word) * RPROD_W'(w_qin.recip2);
    end

    always_ff @(posedge i_clk) begin
        r_cls    <= i_class_index;
        r_word   <= n_word;
        r_q1     <= n_p1[RECIP_SHIFT +: Q1_W];
        r_q2     <= n_p2[RECIP_SHIFT +: Q2_W];
        r_code_a <= i_code_a;
        r_code_b <= i_code_b;
        r_code_c <= i_code_c;
    end

    // Remainders give the digits, lowest first; the top quotient stays
    // below twice the level count, so one subtract finishes it.
    always_comb begin
        w_qreg    = lspr_class(r_cls);
        w_lv      = w_qreg.levels;
        w_d0      = DIGIT_W'(r_word - WORD_W'({1'b0, r_q1} * WORD_W'(w_lv)));
        w_d1      = DIGIT_W'(r_q1 - Q1_W'(Q1_W'(r_q2) * Q1_W'(w_lv)));
        w_d2      = (r_q2 >= w_lv) ? (r_q2 - w_lv) : r_q2;
        w_grouped = (w_qreg.grp != '0);
        w_nb      = w_grouped ? NBITS_W'(w_qreg.grp) : w_qreg.nbits;
    end

    // Lane requests.
    always_comb begin
        o_req_a.code = w_grouped ? CODE_W'(w_d0) : r_code_a;
        o_req_b.code = w_grouped ? CODE_W'(w_d1) : r_code_b;
        o_req_c.code = w_grouped ? CODE_W'(w_d2) : r_code_c;
        o_req_a.nb   = w_nb;
        o_req_b.nb   = w_nb;
        o_req_c.nb   = w_nb;
        o_req_a.mulc = w_qreg.mulc;
        o_req_b.mulc = w_qreg.mulc;
        o_req_c.mulc = w_qreg.mulc;
        o_req_a.addd = w_qreg.addd;
        o_req_b.addd = w_qreg.addd;
        o_req_c.addd = w_qreg.addd;
    end

endmodule

>>> hdl/lspr_lane.sv
// ----------------------------------------------------------------------------
// Layer II sample requantizer: lane
// Requantizes one level code: MSB inversion, sign extension, Q14 alignment,
// offset D, scale by C and arithmetic shift right.
// ----------------------------------------------------------------------------
module lspr_lane import lspr_pkg::*; (
    input  logic                       i_clk,
    input  t_lane_req                  i_req,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    logic [NBITS_W-1:0]          w_sh;
    logic [CODE_W-1:0]           w_left;
    logic [CODE_W-1:0]           w_flip;
    logic signed [SAMPLE_W-1:0]  w_aligned;
    logic signed [SAMPLE_W-1:0]  n_sum;
    logic signed [2*SAMPLE_W-1:0] n_prod;

    logic signed [SAMPLE_W-1:0]  r_sum;
    logic [MULC_W-1:0]           r_mulc;
    logic signed [SAMPLE_W-1:0]  r_res;

    // Moving the code to the top of the word and shifting back by one
    // aligns every bit count to Q14, and halves the sixteen-bit class.
    always_comb begin
        w_sh      = NBITS_W'(CODE_W) - i_req.nb;
        w_left    = i_req.code << w_sh;
        w_flip    = {~w_left[CODE_W-1], w_left[CODE_W-2:0]};
        w_aligned = $signed(w_flip) >>> 1;
        n_sum     = w_aligned + $signed({{(SAMPLE_W-ADDD_W){1'b0}}, i_req.addd});
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_mulc <= i_req.mulc;
    end

    // Scale by C; the floor shift is a bit select of the product.
    always_comb begin
        n_prod = r_sum * $signed({{(SAMPLE_W-MULC_W){1'b0}}, r_mulc});
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_prod[FRAC_BITS +: SAMPLE_W];
    end

    assign o_sample = r_res;

endmodule

>>> hdl/lspr_merge.sv
// ----------------------------------------------------------------------------
// Layer II sample requantizer: merge
// Joins the three lane results into one item and queues items for the
// output channel.
// ----------------------------------------------------------------------------
module lspr_merge import lspr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    input  logic signed [SAMPLE_W-1:0] i_sample_c,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample_a,
    output logic signed [SAMPLE_W-1:0] o_sample_b,
    output logic signed [SAMPLE_W-1:0] o_sample_c,
    output logic [FIFO_CNT_W-1:0]      o_fill
);

    logic [3*SAMPLE_W-1:0]  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr;
    logic [FIFO_PTR_W-1:0]  r_rd;
    logic [FIFO_CNT_W-1:0]  r_fill;
    logic [FIFO_PTR_W-1:0]  n_wr;
    logic [FIFO_PTR_W-1:0]  n_rd;
    logic [FIFO_CNT_W-1:0]  n_fill;
    logic                   w_pop;

    assign o_valid = (r_fill != '0);
    assign w_pop   = o_valid && !i_stall;

    // Pointer and fill count update.
    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        priority if (i_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= {i_sample_a, i_sample_b, i_sample_c};
        end
    end

    assign o_sample_a = r_mem[r_rd][3*SAMPLE_W-1:2*SAMPLE_W];
    assign o_sample_b = r_mem[r_rd][2*SAMPLE_W-1:SAMPLE_W];
    assign o_sample_c = r_mem[r_rd][SAMPLE_W-1:0];
    assign o_fill     = r_fill;

endmodule

>>> hdl/layer2_sample_requantizer_core.sv
// ----------------------------------------------------------------------------
// Layer II sample requantizer core
// Turns one quantization class and its code bits into three Q14 samples,
// one lane per sample, with a queue in front of the output channel.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while o_stall is low; each of the three lanes is
// a two-stage pipeline that takes a new level code every cycle.
// An accepted item passes the code split, offset add and scale multiply registers,
// is then written to the output queue and leaves it when i_stall is low.
// o_stall rises when items in flight plus queued results reach the queue depth.
// Reset: synchronous active-low reset empties the pipeline and the queue and
// holds o_stall high.
module layer2_sample_requantizer_core import lspr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [CLASS_W-1:0]         i_class_index,
    input  logic [CODE_W-1:0]          i_code_a,
    input  logic [CODE_W-1:0]          i_code_b,
    input  logic [CODE_W-1:0]          i_code_c,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_a,
    output logic signed [SAMPLE_W-1:0] o_sample_b,
    output logic signed [SAMPLE_W-1:0] o_sample_c
);

    t_lane_req                   w_req_a;
    t_lane_req                   w_req_b;
    t_lane_req                   w_req_c;
    logic signed [SAMPLE_W-1:0]  w_lane_a;
    logic signed [SAMPLE_W-1:0]  w_lane_b;
    logic signed [SAMPLE_W-1:0]  w_lane_c;
    logic [FIFO_CNT_W-1:0]       w_fill;
    logic [FIFO_CNT_W:0]         w_occ;
    logic                        w_acc;
    logic                        w_pop;

    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;

    // Admission: every item in flight has a queue slot reserved.
    assign w_occ   = (FIFO_CNT_W+1)'(w_fill) + (FIFO_CNT_W+1)'(r_v1)
                   + (FIFO_CNT_W+1)'(r_v2) + (FIFO_CNT_W+1)'(r_v3);
    assign o_stall = (w_occ >= (FIFO_CNT_W+1)'(FIFO_DEPTH)) || !i_rst_n;
    assign w_acc   = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    // Valid flags that follow each item down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    lspr_split u_split (
        .i_clk         (i_clk),
        .i_class_index (i_class_index),
        .i_code_a      (i_code_a),
        .i_code_b      (i_code_b),
        .i_code_c      (i_code_c),
        .o_req_a       (w_req_a),
        .o_req_b       (w_req_b),
        .o_req_c       (w_req_c)
    );

    lspr_lane u_lane_a (
        .i_clk    (i_clk),
        .i_req    (w_req_a),
        .o_sample (w_lane_a)
    );

    lspr_lane u_lane_b (
        .i_clk    (i_clk),
        .i_req    (w_req_b),
        .o_sample (w_lane_b)
    );

    lspr_lane u_lane_c (
        .i_clk    (i_clk),
        .i_req    (w_req_c),
        .o_sample (w_lane_c)
    );

    lspr_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_v3),
        .i_sample_a (w_lane_a),
        .i_sample_b (w_lane_b),
        .i_sample_c (w_lane_c),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_sample_a (o_sample_a),
        .o_sample_b (o_sample_b),
        .o_sample_c (o_sample_c),
        .o_fill     (w_fill)
    );

    // An accepted item reaches the last lane stage as its valid flag reaches r_v3.
    a_item_reaches_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##3 r_v3)
        else $error("Accepted item did not reach the merge stage.");

    // The queue never holds more than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("Output queue fill count exceeds its depth.");

    // A lane result never arrives at a full queue that is not draining.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((w_fill < FIFO_CNT_W'(FIFO_DEPTH)) || w_pop))
        else $error("Lane result pushed into a full output queue.");

endmodule

>>> test/tb_layer2_sample_requantizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Layer II sample requantizer core testbench
// Sends class and code items through the valid/stall input channel. Each
// accepted item is requantized by a predictor in this file. Every result on
// the output channel is compared with the oldest predicted sample triplet.
// Directed items cover every defined class, the field extremes, grouped codewords
// beyond the level cube, the sixteen-bit class and two unused classes. Random
// items then run under three different idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_layer2_sample_requantizer_core;
    import lspr_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int USED_CLASSES = 17;
    localparam int PHASE_ITEMS  = 600;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        logic [SAMPLE_W-1:0] c;
    } t_sample_triplet;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [CLASS_W-1:0]         i_class_index;
    logic [CODE_W-1:0]          i_code_a;
    logic [CODE_W-1:0]          i_code_b;
    logic [CODE_W-1:0]          i_code_c;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [SAMPLE_W-1:0] o_sample_a;
    logic signed [SAMPLE_W-1:0] o_sample_b;
    logic signed [SAMPLE_W-1:0] o_sample_c;

    // Predicted triplets, oldest first.
    t_sample_triplet pending_triplets[$];
    t_sample_triplet wanted_triplet;
    int              n_errors = 0;
    int              send_idle_pct = 0;
    int              stall_pct = 0;

    layer2_sample_requantizer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_class_index (i_class_index),
        .i_code_a      (i_code_a),
        .i_code_b      (i_code_b),
        .i_code_c      (i_code_c),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_a    (o_sample_a),
        .o_sample_b    (o_sample_b),
        .o_sample_c    (o_sample_c)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Quantization class constants: level count, grouped digit width (zero
    // when the three codes are separate), code bits, scale C and offset D.
    function automatic void class_params(input int cls, output int levels,
                                         output int group_bits, output int code_bits,
                                         output longint mul_c, output longint add_d);
        levels     = 0;
        group_bits = 0;
        code_bits  = cls;
        case (cls)
            0:  begin levels = 3; group_bits = 2; code_bits = 5;
                      mul_c = 'h5555; add_d = 'h2000; end
            1:  begin levels = 5; group_bits = 3; code_bits = 7;
                      mul_c = 'h6666; add_d = 'h2000; end
            2:  begin code_bits = 3; mul_c = 'h4925; add_d = 'h1000; end
            3:  begin levels = 9; group_bits = 4; code_bits = 10;
                      mul_c = 'h71c7; add_d = 'h2000; end
            4:  begin mul_c = 'h4444; add_d = 'h0800; end
            5:  begin mul_c = 'h4211; add_d = 'h0400; end
            6:  begin mul_c = 'h4104; add_d = 'h0200; end
            7:  begin mul_c = 'h4081; add_d = 'h0100; end
            8:  begin mul_c = 'h4040; add_d = 'h0080; end
            9:  begin mul_c = 'h4020; add_d = 'h0040; end
            10: begin mul_c = 'h4010; add_d = 'h0020; end
            11: begin mul_c = 'h4008; add_d = 'h0010; end
            12: begin mul_c = 'h4004; add_d = 'h0008; end
            13: begin mul_c = 'h4002; add_d = 'h0004; end
            14: begin mul_c = 'h4001; add_d = 'h0002; end
            15: begin mul_c = 'h4001; add_d = 'h0001; end
            default: begin mul_c = 'h4000; add_d = 'h0001; end
        endcase
    endfunction

    // Requantize one level code of nb bits into a Q14 sample.
    function automatic logic [SAMPLE_W-1:0] requantize_level(input longint code,
                                                             input int nb,
                                                             input longint mul_c,
                                                             input longint add_d);
        longint half_step;
        longint level;
        longint aligned;
        longint prod;
        half_step = longint'(1) << (nb - 1);
        level     = (code & ((half_step << 1) - 1)) ^ half_step;
        if ((level & half_step) != 0)
            level = level - (half_step << 1);
        // The sixteen-bit class cannot be shifted left; it drops one bit instead.
        if (nb - 1 <= FRAC_BITS)
            aligned = level * (longint'(1) << (FRAC_BITS - (nb - 1)));
        else
            aligned = level >>> 1;
        prod = ((aligned + add_d) * mul_c) >>> FRAC_BITS;
        return prod[SAMPLE_W-1:0];
    endfunction

    // Predict the three samples of one item.
    function automatic t_sample_triplet requantize_triplet(input logic [CLASS_W-1:0] cls,
                                                           input logic [CODE_W-1:0] code_a,
                                                           input logic [CODE_W-1:0] code_b,
                                                           input logic [CODE_W-1:0] code_c);
        int                  levels;
        int                  group_bits;
        int                  code_bits;
        longint              mul_c;
        longint              add_d;
        longint              word;
        int                  k;
        logic [SAMPLE_W-1:0] digit_sample[3];
        t_sample_triplet     result;
        result = '0;
        if (cls >= USED_CLASSES)
            return result;
        class_params(cls, levels, group_bits, code_bits, mul_c, add_d);
        if (group_bits != 0) begin
            // Grouped codeword: lowest base-levels digit first.
            word = code_a & ((longint'(1) << code_bits) - 1);
            for (k = 0; k < 3; k++) begin
                digit_sample[k] = requantize_level(word % levels, group_bits, mul_c, add_d);
                word            = word / levels;
            end
        end else begin
            digit_sample[0] = requantize_level(code_a, code_bits, mul_c, add_d);
            digit_sample[1] = requantize_level(code_b, code_bits, mul_c, add_d);
            digit_sample[2] = requantize_level(code_c, code_bits, mul_c, add_d);
        end
        result.a = digit_sample[0];
        result.b = digit_sample[1];
        result.c = digit_sample[2];
        return result;
    endfunction

    // Offer one item, with a random gap first, and hold it until accepted.
    task automatic send_item(input logic [CLASS_W-1:0] cls, input logic [CODE_W-1:0] code_a,
                             input logic [CODE_W-1:0] code_b,
                             input logic [CODE_W-1:0] code_c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_class_index <= cls;
        i_code_a      <= code_a;
        i_code_b      <= code_b;
        i_code_c      <= code_c;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_triplets.push_back(requantize_triplet(cls, code_a, code_b, code_c));
    endtask

    // Stop sending until every predicted triplet has come out.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_triplets.size() != 0)
            @(posedge i_clk);
    endtask

    // Every defined class with all-ones, all-zeros and alternating codes. All-ones
    // codewords of the grouped classes lie beyond the level cube.
    task automatic test_class_sweep();
        int cls;
        for (cls = 0; cls < USED_CLASSES; cls++)
            send_item(CLASS_W'(cls), 16'hFFFF, 16'h0000, cls[0] ? 16'hAAAA : 16'h5555);
    endtask

    // Largest codewords inside the level cube, and an all-zero codeword.
    task automatic test_grouped_codewords();
        send_item(5'd0, 16'd26, 16'hFFFF, 16'hFFFF);
        send_item(5'd1, 16'd124, 16'h0000, 16'h0000);
        send_item(5'd3, 16'd728, 16'h1234, 16'h8765);
        send_item(5'd3, 16'hFC00, 16'h0000, 16'h0000);
    endtask

    // Sixteen-bit class at both ends of the signed code range.
    task automatic test_sixteen_bit_class();
        send_item(5'd16, 16'h8000, 16'h7FFF, 16'h0001);
    endtask

    // Classes without a meaning give zero samples.
    task automatic test_unused_classes();
        send_item(5'd17, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Random code, with the extremes now and then.
    function automatic logic [CODE_W-1:0] random_code();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CODE_W'($urandom);
    endfunction

    // Random items, mostly over the defined classes.
    task automatic test_random_stream(input int count);
        int                 n;
        logic [CLASS_W-1:0] cls;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < 6)
                cls = CLASS_W'($urandom_range(31, USED_CLASSES));
            else
                cls = CLASS_W'($urandom_range(USED_CLASSES - 1, 0));
            send_item(cls, random_code(), random_code(), random_code());
        end
    endtask

    // Random receiver stall.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic check_sample(input string name, input logic [SAMPLE_W-1:0] wanted,
                                input logic [SAMPLE_W-1:0] got);
        if (wanted !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                     $signed(wanted), $signed(got));
            n_errors++;
        end
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_triplets.size() == 0) begin
                $display("%0t: unexpected result %0d %0d %0d", $time,
                         o_sample_a, o_sample_b, o_sample_c);
                n_errors++;
            end else begin
                wanted_triplet = pending_triplets.pop_front();
                check_sample("sample_a", wanted_triplet.a, o_sample_a);
                check_sample("sample_b", wanted_triplet.b, o_sample_b);
                check_sample("sample_c", wanted_triplet.c, o_sample_c);
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_class_index = '0;
        i_code_a      = '0;
        i_code_b      = '0;
        i_code_c      = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 31;
        stall_pct     = 82;
        test_class_sweep();
        test_grouped_codewords();
        test_sixteen_bit_class();
        test_unused_classes();
        wait_for_results();

        test_random_stream(PHASE_ITEMS);
        wait_for_results();

        send_idle_pct = 82;
        stall_pct     = 31;
        test_random_stream(PHASE_ITEMS);
        wait_for_results();

        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_stream(PHASE_ITEMS);
        wait_for_results();

        // Give a stray extra result time to show up.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_layer2_sample_requantizer_core: clean");
        else
            $display("tb_layer2_sample_requantizer_core: errors");
        $finish;
    end

    // Run time limit.
    initial begin
        #5_000_000;
        $display("tb_layer2_sample_requantizer_core: errors");
        $finish;
    end

endmodule
